FILE: sv/tbfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_pkg
// Shared widths, register indexes and record types of the time-bin feature
// extractor.
// ----------------------------------------------------------------------------
package tbfe_pkg;

    localparam int SAMPLE_W       = 10;
    localparam int THR_W          = 12;
    localparam int COUNT_W        = 5;
    localparam int BIN_W          = 5;
    localparam int CLUSTER_W      = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int BINS_PER_EVENT = 27;

    localparam logic [CLUSTER_W-1:0] CLUSTER_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PION_MAX     = 2'd0,
        CFG_PION_AVG     = 2'd1,
        CFG_ELECTRON_AVG = 2'd2,
        CFG_CLUSTER      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [THR_W-1:0] pion_max;
        logic [THR_W-1:0] pion_avg;
        logic [THR_W-1:0] electron_avg;
        logic [THR_W-1:0] cluster;
    } t_thresholds;

    typedef struct packed {
        logic [COUNT_W-1:0]   above_pion_max;
        logic [COUNT_W-1:0]   above_pion_avg;
        logic [COUNT_W-1:0]   above_electron_avg;
        logic [BIN_W-1:0]     peak_bin;
        logic [CLUSTER_W-1:0] cluster_count;
        logic [SAMPLE_W-1:0]  later_cluster_peak;
    } t_record;

endpackage

FILE: sv/tbfe_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbfe_accum
// Per-event feature state: threshold counters, first peak, cluster tracking.
// Offers the finished record on the last bin and clears itself after it.
// ----------------------------------------------------------------------------
module tbfe_accum #(
    parameter int BINS_PER_EVENT = tbfe_pkg::BINS_PER_EVENT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbfe_pkg::t_thresholds         i_thr,
    input  logic                          i_take,
    input  logic [tbfe_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_last,
    output tbfe_pkg::t_record             o_record
);
    import tbfe_pkg::*;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS_PER_EVENT - 1);

    logic [BIN_W-1:0]     r_bin,      n_bin;
    logic [SAMPLE_W-1:0]  r_prev,     n_prev;
    logic [COUNT_W-1:0]   r_cnt_pmax, n_cnt_pmax;
    logic [COUNT_W-1:0]   r_cnt_pavg, n_cnt_pavg;
    logic [COUNT_W-1:0]   r_cnt_eavg, n_cnt_eavg;
    logic [SAMPLE_W-1:0]  r_peak_val, n_peak_val;
    logic [BIN_W-1:0]     r_peak_idx, n_peak_idx;
    logic [CLUSTER_W-1:0] r_clusters, n_clusters;
    logic                 r_inside,   n_inside;
    logic [SAMPLE_W-1:0]  r_later,    n_later;

    logic [THR_W-1:0] s4;
    logic [THR_W-1:0] p4;
    logic             above_cluster;
    logic             crossing;

    assign s4            = {i_sample, 2'b00};
    assign p4            = {r_prev, 2'b00};
    assign above_cluster = s4 > i_thr.cluster;
    assign crossing      = (r_bin != '0) && above_cluster && (p4 < i_thr.cluster);
    assign o_last        = (r_bin == LAST_BIN);

    always_comb begin
        n_cnt_pmax = r_cnt_pmax + COUNT_W'(s4 > i_thr.pion_max);
        n_cnt_pavg = r_cnt_pavg + COUNT_W'(s4 > i_thr.pion_avg);
        n_cnt_eavg = r_cnt_eavg + COUNT_W'(s4 > i_thr.electron_avg);

        n_peak_val = r_peak_val;
        n_peak_idx = r_peak_idx;
        if (i_sample > r_peak_val) begin
            n_peak_val = i_sample;
            n_peak_idx = r_bin;
        end

        n_clusters = r_clusters;
        n_inside   = r_inside;
        if (crossing) begin
            if (r_clusters != CLUSTER_MAX) begin
                n_clusters = r_clusters + 1'b1;
            end
            if (n_clusters >= CLUSTER_W'(2)) begin
                n_inside = 1'b1;
            end
        end

        // the crossing sample itself counts toward the later peak
        n_later = r_later;
        if (n_inside) begin
            if (above_cluster) begin
                if (i_sample > r_later) begin
                    n_later = i_sample;
                end
            end else begin
                n_inside = 1'b0;
            end
        end

        n_prev = i_sample;
        n_bin  = r_bin + 1'b1;

        o_record.above_pion_max     = n_cnt_pmax;
        o_record.above_pion_avg     = n_cnt_pavg;
        o_record.above_electron_avg = n_cnt_eavg;
        o_record.peak_bin           = n_peak_idx;
        o_record.cluster_count      = n_clusters;
        o_record.later_cluster_peak = n_later;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin      <= '0;
            r_prev     <= '0;
            r_cnt_pmax <= '0;
            r_cnt_pavg <= '0;
            r_cnt_eavg <= '0;
            r_peak_val <= '0;
            r_peak_idx <= '0;
            r_clusters <= '0;
            r_inside   <= 1'b0;
            r_later    <= '0;
        end else if (i_take) begin
            if (o_last) begin
                // end of event: start the next one clean
                r_bin      <= '0;
                r_prev     <= '0;
                r_cnt_pmax <= '0;
                r_cnt_pavg <= '0;
                r_cnt_eavg <= '0;
                r_peak_val <= '0;
                r_peak_idx <= '0;
                r_clusters <= '0;
                r_inside   <= 1'b0;
                r_later    <= '0;
            end else begin
                r_bin      <= n_bin;
                r_prev     <= n_prev;
                r_cnt_pmax <= n_cnt_pmax;
                r_cnt_pavg <= n_cnt_pavg;
                r_cnt_eavg <= n_cnt_eavg;
                r_peak_val <= n_peak_val;
                r_peak_idx <= n_peak_idx;
                r_clusters <= n_clusters;
                r_inside   <= n_inside;
                r_later    <= n_later;
            end
        end
    end

endmodule

FILE: sv/time_bin_feature_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_bin_feature_extractor_unit
// Feature record per detector event from a stream of ADC time-bin samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_sample) carries the samples of one
//   event in time order, BINS_PER_EVENT requests per event. One sample is
//   taken per clock while o_stall is low. After the last sample of an event
//   is taken, the record appears on the output channel (o_valid / i_stall /
//   o_* fields) in the next cycle. Throughput: one sample per cycle.
//   The output register holds one record; while it is stalled the block
//   still takes samples, and stalls only the last sample of the next event
//   until the pending record leaves.
//   Configuration (i_cfg_valid / o_cfg_ready) writes the four thresholds,
//   quarter ADC counts; o_cfg_ready is always high. Write between events.
//   Reset (synchronous, active low) clears thresholds, event state and the
//   output valid flag.
// ----------------------------------------------------------------------------
module time_bin_feature_extractor_unit #(
    parameter int BINS_PER_EVENT = tbfe_pkg::BINS_PER_EVENT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tbfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tbfe_pkg::THR_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [tbfe_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tbfe_pkg::COUNT_W-1:0]   o_above_pion_max,
    output logic [tbfe_pkg::COUNT_W-1:0]   o_above_pion_avg,
    output logic [tbfe_pkg::COUNT_W-1:0]   o_above_electron_avg,
    output logic [tbfe_pkg::BIN_W-1:0]     o_peak_bin,
    output logic [tbfe_pkg::CLUSTER_W-1:0] o_cluster_count,
    output logic [tbfe_pkg::SAMPLE_W-1:0]  o_later_cluster_peak
);
    import tbfe_pkg::*;

    t_thresholds r_thr;
    t_record     r_out;
    logic        r_out_valid;
    t_record     next_record;
    logic        last_bin;
    logic        take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PION_MAX:     r_thr.pion_max     <= i_cfg_data;
                CFG_PION_AVG:     r_thr.pion_avg     <= i_cfg_data;
                CFG_ELECTRON_AVG: r_thr.electron_avg <= i_cfg_data;
                CFG_CLUSTER:      r_thr.cluster      <= i_cfg_data;
                default:          r_thr              <= r_thr;
            endcase
        end
    end

    // hold only the request that would overwrite a stalled record
    assign o_stall = last_bin && r_out_valid && i_stall;
    assign take    = i_valid && !o_stall;

    tbfe_accum #(
        .BINS_PER_EVENT(BINS_PER_EVENT)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_thr    (r_thr),
        .i_take   (take),
        .i_sample (i_sample),
        .o_last   (last_bin),
        .o_record (next_record)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && last_bin) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && last_bin) begin
            r_out <= next_record;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_above_pion_max     = r_out.above_pion_max;
    assign o_above_pion_avg     = r_out.above_pion_avg;
    assign o_above_electron_avg = r_out.above_electron_avg;
    assign o_peak_bin           = r_out.peak_bin;
    assign o_cluster_count      = r_out.cluster_count;
    assign o_later_cluster_peak = r_out.later_cluster_peak;

    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && last_bin))
        else $error("input stalled without a pending record on the last bin");

    a_last_gives_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && last_bin) |=> o_valid)
        else $error("last sample taken but no record presented");

    a_peak_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_peak_bin < BIN_W'(BINS_PER_EVENT)))
        else $error("peak bin beyond the event length");

    a_mid_event_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !(take && last_bin)) |=> !o_valid)
        else $error("record appeared without an event end");

endmodule
